// ===== rtl/nrt_pkg.sv =====
// Shared constants and types of the node record table.
package nrt_pkg;

    localparam int CAPACITY = 1024;
    localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    localparam logic OP_REMEMBER = 1'b0;
    localparam logic OP_LOOKUP   = 1'b1;

    typedef struct packed {
        logic [31:0] id;
        logic [7:0]  model;
        logic [3:0]  role;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        t_entry            wdata;
        logic [SLOT_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic       hit;
        logic       evicted;
        logic [7:0] model;
        logic [3:0] role;
    } t_result;

    typedef struct packed {
        logic busy;
        logic full;
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

// ===== rtl/nrt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module nrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/nrt_ctrl.sv =====
// Scan sequencer: searches the table one entry a cycle, then updates it on a remember.
module nrt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_op,
    input  logic [31:0]      i_node_id,
    input  logic [7:0]       i_model_code,
    input  logic [3:0]       i_role_code,
    output nrt_pkg::t_ram_req o_ram,
    input  nrt_pkg::t_entry   i_rdata,
    output logic             o_res_valid,
    output nrt_pkg::t_result  o_res,
    input  logic             i_res_ready,
    output nrt_pkg::t_status  o_status
);
    import nrt_pkg::*;

    t_state              r_state, n_state;
    logic                r_op, n_op;
    logic [31:0]         r_id, n_id;
    logic [7:0]          r_model, n_model;
    logic [3:0]          r_role, n_role;
    logic [SLOT_W-1:0]   r_idx, n_idx;
    logic                r_hit, n_hit;
    logic [7:0]          r_smodel, n_smodel;
    logic [3:0]          r_srole, n_srole;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [SLOT_W-1:0]   r_oldest, n_oldest;

    logic                full;
    logic                last;
    logic [SLOT_W-1:0]   slot;
    logic [7:0]          base_model;
    logic [3:0]          base_role;
    logic [7:0]          out_model;
    logic [3:0]          out_role;

    assign full = (r_count == COUNT_W'(CAPACITY));
    assign last = ((COUNT_W'(r_idx) + COUNT_W'(1)) == r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_oldest <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_oldest <= n_oldest;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_id     <= n_id;
        r_model  <= n_model;
        r_role   <= n_role;
        r_idx    <= n_idx;
        r_hit    <= n_hit;
        r_smodel <= n_smodel;
        r_srole  <= n_srole;
    end

    // Stored fields that the update starts from: zero for a fresh record.
    assign base_model = r_hit ? r_smodel : 8'd0;
    assign base_role  = r_hit ? r_srole  : 4'd0;
    assign out_model  = (r_op == OP_REMEMBER && r_model != 8'd0) ? r_model : base_model;
    assign out_role   = (r_op == OP_REMEMBER && r_role  != 4'd0) ? r_role  : base_role;

    always_comb begin
        if (r_hit) begin
            slot = r_idx;
        end else if (full) begin
            slot = r_oldest;
        end else begin
            slot = r_count[SLOT_W-1:0];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_id     = r_id;
        n_model  = r_model;
        n_role   = r_role;
        n_idx    = r_idx;
        n_hit    = r_hit;
        n_smodel = r_smodel;
        n_srole  = r_srole;
        n_count  = r_count;
        n_oldest = r_oldest;

        o_ram.we    = 1'b0;
        o_ram.waddr = slot;
        o_ram.wdata = '{id: r_id, model: out_model, role: out_role};
        o_ram.raddr = r_idx + SLOT_W'(1);

        o_res_valid   = 1'b0;
        o_res.hit     = r_hit;
        o_res.evicted = (r_op == OP_REMEMBER) && !r_hit && full;
        o_res.model   = out_model;
        o_res.role    = out_role;

        unique case (r_state)
            S_IDLE: begin
                o_ram.raddr = '0;
                if (i_valid) begin
                    n_op    = i_op;
                    n_id    = i_node_id;
                    n_model = i_model_code;
                    n_role  = i_role_code;
                    n_idx   = '0;
                    n_hit   = 1'b0;
                    n_state = (r_count == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                // Read data on the port belongs to entry r_idx.
                if (i_rdata.id == r_id) begin
                    n_hit    = 1'b1;
                    n_smodel = i_rdata.model;
                    n_srole  = i_rdata.role;
                    n_state  = S_DONE;
                end else if (last) begin
                    n_hit   = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end
            S_DONE: begin
                // Hold until the output register can take the transfer.
                if (i_res_ready) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_op == OP_REMEMBER) begin
                        o_ram.we = 1'b1;
                        if (!r_hit) begin
                            if (full) begin
                                n_oldest = (r_oldest == SLOT_W'(CAPACITY - 1)) ?
                                           '0 : r_oldest + SLOT_W'(1);
                            end else begin
                                n_count = r_count + COUNT_W'(1);
                            end
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_status.busy = (r_state != S_IDLE);
    assign o_status.full = full;

endmodule

// ===== rtl/node_record_table_fifo_evict_core.sv =====
// Top level of the node record table: sequencer, record memory and output register.
//
// Input channel (i_valid / o_stall) carries one command: op 0 remembers or
// updates the record of i_node_id, op 1 looks it up. Output channel
// (o_valid / i_stall) returns one result per command: hit, evicted and the
// model and role codes held for the id afterwards (zeros on a lookup miss).
// Commands are handled one at a time. After the accept, the scan reads the held
// records in slot order until the id matches or the last one is read (none when
// the table is empty); the update cycle then writes the table on a remember and
// hands over the result. The scan walks the record memory's single read port one
// entry per cycle, the read data being registered.
// Results sit in an output register; the next command is accepted while a
// result waits there, and its own result holds in the update cycle, without
// writing the table, until the receiver stops stalling.
// Reset empties the table at once through the fill count and the oldest-slot
// pointer; the memory is not cleared and needs no clearing pass.
// When full, remembering a new id replaces the oldest inserted record.
module node_record_table_fifo_evict_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [31:0] i_node_id,
    input  logic [7:0]  i_model_code,
    input  logic [3:0]  i_role_code,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_hit,
    output logic        o_evicted,
    output logic [7:0]  o_stored_model,
    output logic [3:0]  o_stored_role
);
    import nrt_pkg::*;

    t_ram_req ram_req;
    t_entry   ram_rdata;
    logic     res_valid;
    logic     res_ready;
    t_result  res;
    t_status  status;

    logic     r_out_valid, n_out_valid;
    t_result  r_out, n_out;

    nrt_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_op         (i_op),
        .i_node_id    (i_node_id),
        .i_model_code (i_model_code),
        .i_role_code  (i_role_code),
        .o_ram        (ram_req),
        .i_rdata      (ram_rdata),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_ready  (res_ready),
        .o_status     (status)
    );

    nrt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    assign res_ready = !r_out_valid || !i_stall;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (res_ready) begin
            n_out_valid = res_valid;
            if (res_valid) begin
                n_out = res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid        = r_out_valid;
    assign o_hit          = r_out.hit;
    assign o_evicted      = r_out.evicted;
    assign o_stored_model = r_out.model;
    assign o_stored_role  = r_out.role;

    // A result is only produced when the output register has room.
    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> res_ready)
        else $error("result produced while output register is blocked");

    a_res_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |=> o_valid)
        else $error("produced result did not reach the output register");

    // Replacement happens only on a miss into a full table.
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_evicted) |-> (!o_hit && status.full))
        else $error("eviction reported on a hit or a table that is not full");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> status.busy)
        else $error("sequencer not busy after a transfer was accepted");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench of the node record table with oldest-first replacement.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nrt_pkg::*;

    // The limit allows for the slowest items, with the longest scan, stalls and gaps;
    // about 580 items are sent, so this is several times the worst case.
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int N_DIRECTED  = 21;
    localparam int N_RANDOM    = 519;
    localparam int N_CALM      = 40;
    localparam int RECENT_KEEP = 32;
    localparam int PRINT_CAP   = 40;

    typedef struct packed {
        logic        op;
        logic [31:0] id;
        logic [7:0]  model;
        logic [3:0]  role;
        logic        typed;
        t_result     res;
    } t_row;

    localparam t_result NO_RES = '0;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        o_stall;
    logic        i_op           = OP_REMEMBER;
    logic [31:0] i_node_id      = '0;
    logic [7:0]  i_model_code   = '0;
    logic [3:0]  i_role_code    = '0;
    logic        o_valid;
    logic        i_stall        = 1'b0;
    logic        o_hit;
    logic        o_evicted;
    logic [7:0]  o_stored_model;
    logic [3:0]  o_stored_role;

    node_record_table_fifo_evict_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_node_id      (i_node_id),
        .i_model_code   (i_model_code),
        .i_role_code    (i_role_code),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_hit          (o_hit),
        .o_evicted      (o_evicted),
        .o_stored_model (o_stored_model),
        .o_stored_role  (o_stored_role)
    );

    // Table mirror: slot contents, fill count, ring pointer and an id-to-slot index.
    logic [31:0] rec_ids    [CAPACITY];
    logic [7:0]  rec_models [CAPACITY];
    logic [3:0]  rec_roles  [CAPACITY];
    int unsigned rec_count  = 0;
    int unsigned rec_oldest = 0;
    int unsigned slot_of_id [bit [31:0]];
    logic [31:0] recent_evicted [$];

    t_result     expected_records [$];
    t_result     want;
    bit          calm        = 1'b0;
    int          stall_left  = 0;
    int          errors      = 0;
    int          items_sent  = 0;
    int          results_seen = 0;
    int          hit_count   = 0;
    int          evict_count = 0;
    int          cycle_count = 0;

    // Empty table at the start: misses, inserts, partial updates, lookups that ignore codes.
    t_row directed_rows [N_DIRECTED] = '{
        '{OP_LOOKUP,   32'h0000_0000, 8'h00, 4'h0, 1'b1, '{1'b0, 1'b0, 8'h00, 4'h0}},
        '{OP_REMEMBER, 32'h0000_0000, 8'h00, 4'h0, 1'b1, '{1'b0, 1'b0, 8'h00, 4'h0}},
        '{OP_LOOKUP,   32'h0000_0000, 8'h00, 4'h0, 1'b1, '{1'b1, 1'b0, 8'h00, 4'h0}},
        '{OP_REMEMBER, 32'hFFFF_FFFF, 8'hFF, 4'hF, 1'b1, '{1'b0, 1'b0, 8'hFF, 4'hF}},
        '{OP_LOOKUP,   32'hFFFF_FFFF, 8'h00, 4'h0, 1'b1, '{1'b1, 1'b0, 8'hFF, 4'hF}},
        '{OP_REMEMBER, 32'hFFFF_FFFF, 8'h00, 4'h0, 1'b1, '{1'b1, 1'b0, 8'hFF, 4'hF}},
        '{OP_REMEMBER, 32'hFFFF_FFFF, 8'h01, 4'h0, 1'b1, '{1'b1, 1'b0, 8'h01, 4'hF}},
        '{OP_REMEMBER, 32'hFFFF_FFFF, 8'h00, 4'h1, 1'b1, '{1'b1, 1'b0, 8'h01, 4'h1}},
        '{OP_REMEMBER, 32'h0000_0000, 8'h80, 4'h8, 1'b1, '{1'b1, 1'b0, 8'h80, 4'h8}},
        '{OP_LOOKUP,   32'h0000_0001, 8'h00, 4'h0, 1'b1, '{1'b0, 1'b0, 8'h00, 4'h0}},
        '{OP_LOOKUP,   32'hFFFF_FFFE, 8'hFF, 4'hF, 1'b1, '{1'b0, 1'b0, 8'h00, 4'h0}},
        '{OP_LOOKUP,   32'h0000_0000, 8'hFF, 4'hF, 1'b1, '{1'b1, 1'b0, 8'h80, 4'h8}},
        '{OP_REMEMBER, 32'hA5A5_A5A5, 8'h00, 4'hF, 1'b1, '{1'b0, 1'b0, 8'h00, 4'hF}},
        '{OP_REMEMBER, 32'h5A5A_5A5A, 8'hFF, 4'h0, 1'b1, '{1'b0, 1'b0, 8'hFF, 4'h0}},
        '{OP_REMEMBER, 32'h8000_0000, 8'h7F, 4'h7, 1'b1, '{1'b0, 1'b0, 8'h7F, 4'h7}},
        '{OP_REMEMBER, 32'h7FFF_FFFF, 8'h55, 4'hA, 1'b0, NO_RES},
        '{OP_LOOKUP,   32'h8000_0000, 8'h00, 4'h0, 1'b0, NO_RES},
        '{OP_REMEMBER, 32'hA5A5_A5A5, 8'h3C, 4'h0, 1'b0, NO_RES},
        '{OP_REMEMBER, 32'h0000_0001, 8'hAA, 4'h5, 1'b0, NO_RES},
        '{OP_LOOKUP,   32'hFFFF_FFFF, 8'h00, 4'h0, 1'b0, NO_RES},
        '{OP_LOOKUP,   32'h0000_0001, 8'h0F, 4'h3, 1'b0, NO_RES}
    };

    function automatic t_result apply_record_op(input logic op, input logic [31:0] id,
                                                input logic [7:0] model,
                                                input logic [3:0] role);
        t_result     r;
        int unsigned slot;
        bit          found;
        r     = '0;
        found = slot_of_id.exists(id);
        r.hit = found;
        if (found) hit_count++;
        if (op == OP_LOOKUP) begin
            if (found) begin
                r.model = rec_models[slot_of_id[id]];
                r.role  = rec_roles[slot_of_id[id]];
            end
            return r;
        end
        if (found) begin
            slot = slot_of_id[id];
        end else begin
            if (rec_count < CAPACITY) begin
                slot = rec_count;
                rec_count++;
            end else begin
                // replace the oldest record and advance the ring pointer
                slot       = rec_oldest;
                rec_oldest = (rec_oldest == CAPACITY - 1) ? 0 : rec_oldest + 1;
                r.evicted  = 1'b1;
                evict_count++;
                slot_of_id.delete(rec_ids[slot]);
                recent_evicted.push_back(rec_ids[slot]);
                if (recent_evicted.size() > RECENT_KEEP) void'(recent_evicted.pop_front());
            end
            rec_ids[slot]    = id;
            rec_models[slot] = '0;
            rec_roles[slot]  = '0;
            slot_of_id[id]   = slot;
        end
        if (model != 0) rec_models[slot] = model;
        if (role != 0) rec_roles[slot] = role;
        r.model = rec_models[slot];
        r.role  = rec_roles[slot];
        return r;
    endfunction

    function automatic logic [31:0] rand_id();
        int unsigned k;
        k = $urandom_range(0, 31);
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 15);
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
            2:       return 32'h1 << k;
            3:       return ~(32'h1 << k);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] fresh_id();
        logic [31:0] id;
        id = rand_id();
        while (slot_of_id.exists(id)) id = rand_id();
        return id;
    endfunction

    function automatic logic [7:0] rand_model();
        return ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [3:0] rand_role();
        return ($urandom_range(0, 2) == 0) ? 4'h0 : 4'($urandom_range(1, 15));
    endfunction

    task automatic flag_mismatch(input string what);
        if (errors < PRINT_CAP) $display("mismatch at cycle %0d: %s", cycle_count, what);
        errors++;
    endtask

    // Entered at a clock edge; returns at the edge of the transfer with valid still high.
    task automatic send_item(input logic op, input logic [31:0] id,
                             input logic [7:0] model, input logic [3:0] role);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_op         <= op;
        i_node_id    <= id;
        i_model_code <= model;
        i_role_code  <= role;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_records.push_back(apply_record_op(op, id, model, role));
        items_sent++;
    endtask

    task automatic send_mixed();
        logic        op;
        logic [31:0] id;
        op = ($urandom_range(0, 1) == 0) ? OP_REMEMBER : OP_LOOKUP;
        case ($urandom_range(0, 9)) inside
            [0:3]: id = (rec_count != 0) ? rec_ids[$urandom_range(0, rec_count - 1)]
                                         : rand_id();
            4: id = (recent_evicted.size() != 0)
                    ? recent_evicted[$urandom_range(0, recent_evicted.size() - 1)]
                    : rand_id();
            default: id = rand_id();
        endcase
        send_item(op, id, rand_model(), rand_role());
    endtask

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Receiver stalls in random bursts; no new burst starts once calm is set.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 15);
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            results_seen++;
            if (expected_records.size() == 0) begin
                flag_mismatch("result transfer with nothing expected");
            end else begin
                want = expected_records.pop_front();
                if (o_hit !== want.hit)
                    flag_mismatch($sformatf("hit %b, expected %b", o_hit, want.hit));
                if (o_evicted !== want.evicted)
                    flag_mismatch($sformatf("evicted %b, expected %b", o_evicted, want.evicted));
                if (o_stored_model !== want.model)
                    flag_mismatch($sformatf("model %h, expected %h", o_stored_model, want.model));
                if (o_stored_role !== want.role)
                    flag_mismatch($sformatf("role %h, expected %h", o_stored_role, want.role));
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout with %0d results outstanding", expected_records.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < N_DIRECTED; n++) begin
            send_item(directed_rows[n].op, directed_rows[n].id,
                      directed_rows[n].model, directed_rows[n].role);
            if (directed_rows[n].typed) begin
                void'(expected_records.pop_back());
                expected_records.push_back(directed_rows[n].res);
            end
        end

        // random mix, biased toward new ids so the table keeps growing
        repeat (N_RANDOM) begin
            if ($urandom_range(0, 3) == 0) send_item(OP_REMEMBER, fresh_id(), rand_model(),
                                                     rand_role());
            else send_mixed();
        end

        calm = 1'b1;
        repeat (N_CALM) send_mixed();
        i_valid <= 1'b0;

        while (expected_records.size() != 0) @(posedge i_clk);
        repeat (CAPACITY + 8) @(posedge i_clk);

        $display("sent %0d commands: %0d records held at the end, %0d hits, %0d replacements",
                 items_sent, rec_count, hit_count, evict_count);
        $display("checked %0d results in %0d cycles, %0d mismatches",
                 results_seen, cycle_count, errors);
        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule
